@@ rtl/core/mimr_pkg.sv @@
// Shared types, constants and fixed-point helpers of the minimal ionic model derivative unit.
package mimr_pkg;

  localparam int NUM_CFG     = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int TQ_BITS     = 25;
  localparam int SIG_LAT     = TQ_BITS + 8;
  localparam int SD_LEN      = SIG_LAT - 2;
  localparam int QD_BITS     = 29;

  typedef enum logic [2:0] {
    CFG_REST_OFFSET,
    CFG_UPPER_POTENTIAL,
    CFG_FAST_THRESHOLD,
    CFG_SLOW_THRESHOLD,
    CFG_V_TAU_THRESHOLD,
    CFG_O_THRESHOLD,
    CFG_SO_MIDPOINT,
    CFG_S_MIDPOINT
  } cfg_idx_t;

  localparam logic signed [26:0] CFG_RESET [NUM_CFG] = '{
    27'sd0, 27'sd27011318, 27'sd5033165, 27'sd2181038,
    27'sd1677722, 27'sd83886, 27'sd10066330, 27'sd15245423
  };

  localparam logic signed [31:0] ONE          = 32'sd16777216;
  localparam logic [24:0]        ONE_U        = 25'd16777216;
  localparam logic signed [31:0] R_TAUV1      = 32'sd209715;
  localparam logic signed [31:0] R_TAUV2      = 32'sd11565708;
  localparam logic signed [31:0] R_TAUVP      = 32'sd11565708;
  localparam logic signed [31:0] R_TAUWP      = 32'sd59919;
  localparam logic signed [31:0] R_TAUFI      = 32'sd215092513;
  localparam logic signed [31:0] R_TAUO1      = 32'sd40920;
  localparam logic signed [31:0] R_TAUO2      = 32'sd2396745;
  localparam logic signed [31:0] R_TAUS1      = 32'sd6136060;
  localparam logic signed [31:0] R_TAUS2      = 32'sd4194304;
  localparam logic signed [31:0] R_TAUSI      = 32'sd4956488;
  localparam logic signed [31:0] C_KSO        = 32'sd35232154;
  localparam logic signed [31:0] C_KS         = 32'sd35222087;
  localparam logic signed [31:0] C_UW         = 32'sd268435;
  localparam logic signed [63:0] C_KW         = 64'sd200;
  localparam logic signed [63:0] C_WINF_GAIN  = 64'sd100;
  localparam logic signed [31:0] C_TAUSO1     = 32'sd1526726656;
  localparam logic signed [31:0] C_TAUSO_DIFF = -32'sd1513304883;
  localparam logic signed [31:0] C_TAUW1      = 32'sd1174405120;
  localparam logic signed [31:0] C_TAUW_DIFF  = -32'sd1040187392;
  localparam logic signed [31:0] C_WINFSTAR   = 32'sd8388608;

  localparam logic [32:0] TANH_SAT = 33'd83886080;
  localparam logic [39:0] TC0      = 40'd8856207360;
  localparam logic [39:0] TN1      = 40'd17325;
  localparam logic [39:0] TN2      = 40'd378;
  localparam logic [39:0] TD1      = 40'd62370;
  localparam logic [39:0] TD2      = 40'd3150;
  localparam logic [39:0] TD3      = 40'd28;

  typedef struct packed {
    logic [26:0] mag;
    logic        neg;
    logic        big;
  } tcarry_t;

  typedef struct packed {
    logic               hv;
    logic               hw;
    logic signed [31:0] jfi_mag;
    logic signed [31:0] jsi_mag;
    logic signed [31:0] jso_lin;
    logic signed [31:0] dv;
    logic signed [31:0] dw_fix;
    logic signed [31:0] wg;
    logic [24:0]        gs;
  } side_t;

  typedef struct packed {
    logic               hw;
    logic signed [31:0] jfi_mag;
    logic signed [31:0] jsi_mag;
    logic signed [31:0] jso_lin;
    logic signed [31:0] dv;
    logic signed [31:0] dw_fix;
    logic signed [31:0] ds;
  } tail_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd8388608;
    return sat32(p >>> 24);
  endfunction

endpackage

@@ rtl/core/mimr_sigmoid.sv @@
// Pipelined rational tanh and logistic sigmoid of one Q8.24 argument.
module mimr_sigmoid import mimr_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x,
  output logic [24:0]        sig
);

  logic signed [32:0] xw;
  logic signed [32:0] xmag;
  tcarry_t            a_c;
  logic [18:0]        a_xs;
  tcarry_t            b_c;
  logic [20:0]        b_t;
  tcarry_t            c_c;
  logic [20:0]        c_t;
  logic [25:0]        c_t2;
  tcarry_t            d_c;
  logic [20:0]        d_t;
  logic [25:0]        d_t2;
  logic [30:0]        d_t3;
  tcarry_t            e_c;
  logic [39:0]        e_n1, e_n2, e_d1, e_d2, e_d3, e_t3;
  tcarry_t            f_c;
  logic [39:0]        f_n, f_d;
  logic [39:0]        dq_r [TQ_BITS];
  logic [TQ_BITS-1:0] dq_q [TQ_BITS];
  logic [39:0]        dq_d [TQ_BITS];
  tcarry_t            dq_c [TQ_BITS];
  logic [51:0]        p_prod;
  logic               p_neg, p_big;
  logic [27:0]        rnd;
  logic [24:0]        tmag;

  always_comb begin
    xw   = 33'(x);
    xmag = x[31] ? -xw : xw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_c.mag <= xmag[26:0];
      a_c.neg <= x[31];
      a_c.big <= xmag >= $signed(TANH_SAT);
      a_xs    <= xmag[26:8];
      b_c     <= a_c;
      b_t     <= 21'((38'(a_xs) * 38'(a_xs)) >> 16);
      c_c     <= b_c;
      c_t     <= b_t;
      c_t2    <= 26'((42'(b_t) * 42'(b_t)) >> 16);
      d_c     <= c_c;
      d_t     <= c_t;
      d_t2    <= c_t2;
      d_t3    <= 31'((47'(c_t2) * 47'(c_t)) >> 16);
      e_c     <= d_c;
      e_n1    <= 40'(d_t) * TN1;
      e_n2    <= 40'(d_t2) * TN2;
      e_d1    <= 40'(d_t) * TD1;
      e_d2    <= 40'(d_t2) * TD2;
      e_d3    <= 40'(d_t3) * TD3;
      e_t3    <= 40'(d_t3);
      f_c     <= e_c;
      f_n     <= TC0 + e_n1 + e_n2 + e_t3;
      f_d     <= TC0 + e_d1 + e_d2 + e_d3;
    end
  end

  for (genvar k = 0; k < TQ_BITS; k++) begin : g_div
    logic [39:0]        r_in, d_in, r_nx;
    logic [TQ_BITS-1:0] q_in;
    tcarry_t            c_in;
    logic               b_in, ge;
    logic [40:0]        rr;
    if (k == 0) begin : g_first
      assign r_in = f_n >> 1;
      assign b_in = f_n[0];
      assign q_in = '0;
      assign d_in = f_d;
      assign c_in = f_c;
    end else begin : g_rest
      assign r_in = dq_r[k-1];
      assign b_in = 1'b0;
      assign q_in = dq_q[k-1];
      assign d_in = dq_d[k-1];
      assign c_in = dq_c[k-1];
    end
    always_comb begin
      rr   = {r_in, b_in};
      ge   = rr >= {1'b0, d_in};
      r_nx = ge ? 40'(rr - {1'b0, d_in}) : rr[39:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[k] <= r_nx;
        dq_q[k] <= {q_in[TQ_BITS-2:0], ge};
        dq_d[k] <= d_in;
        dq_c[k] <= c_in;
      end
    end
  end

  always_comb begin
    rnd  = 28'((p_prod + 52'd8388608) >> 24);
    tmag = (p_big || rnd > 28'(ONE_U)) ? ONE_U : rnd[24:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod <= 52'(dq_c[TQ_BITS-1].mag) * 52'(dq_q[TQ_BITS-1]);
      p_neg  <= dq_c[TQ_BITS-1].neg;
      p_big  <= dq_c[TQ_BITS-1].big;
      sig    <= p_neg ? 25'((26'(ONE_U) - 26'(tmag)) >> 1)
                      : 25'((26'(ONE_U) + 26'(tmag)) >> 1);
    end
  end

endmodule

@@ rtl/core/minimal_ionic_model_rhs_unit.sv @@
// Top level of the minimal ionic model derivative unit: four-variable cell state in, derivatives out.
// One node state is taken per cycle and its four saturated Q8.24 derivatives leave in input order;
// the pipeline stalls as a whole only when the output register and its skid stage are both full.
// The depth comes from two restoring dividers that resolve one quotient bit per stage: 25 stages
// inside each tanh unit (three run side by side) and 29 stages in the quotient unit shared by the
// slow outward current and the w gate rate. Threshold registers are written through the cfg
// channel, which is always ready; write them only while no beat is in flight.
module minimal_ionic_model_rhs_unit import mimr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [111:0]           s_tdata,   // potential, gate_v, gate_w, gate_s, zero fill
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [127:0]           m_tdata,   // d_potential, d_gate_v, d_gate_w, d_gate_s
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [26:0]            cfg_data
);

  logic signed [26:0] cfg_regs [NUM_CFG];
  logic               adv;

  logic               s1_valid;
  logic signed [31:0] s1_u;
  logic [24:0]        s1_gv, s1_gw, s1_gs;

  logic               s2_valid;
  logic signed [31:0] s2_d_thv, s2_d_uu, s2_d_uso, s2_d_uo, s2_d_uw, s2_d_us, s2_u100;
  logic               s2_hv, s2_hw, s2_hvm, s2_ho, s2_vinf;
  logic [24:0]        s2_gv, s2_gw, s2_gs;

  logic               s3_valid;
  logic signed [31:0] s3_p1, s3_z1, s3_z2, s3_z3, s3_gws, s3_jso_lin, s3_dv, s3_dw_fix;
  logic signed [31:0] s3_winf;
  logic               s3_hv, s3_hw;
  logic [24:0]        s3_gv, s3_gw, s3_gs;
  logic signed [31:0] dv_a, dv_b, dv_p;

  logic               s4_valid;
  logic signed [31:0] s4_p2, s4_q2, s4_wg, s4_jso_lin, s4_dv, s4_dw_fix;
  logic               s4_hv, s4_hw;
  logic [24:0]        s4_gs;

  logic               s5_valid;
  side_t              s5_side;

  logic [SD_LEN-1:0]  sd_valid;
  side_t              sd [SD_LEN];
  side_t              sd_last;
  logic [24:0]        sig1, sig2, sig3;

  logic               s6_valid;
  logic signed [31:0] s6_tauso, s6_tauwm, s6_wg;
  tail_t              s6_tail;

  logic               s7_valid;
  logic [55:0]        s7_x;
  logic [30:0]        s7_b;
  logic               s7_neg;
  tail_t              s7_tail;
  logic [31:0]        wg_mag;

  logic [QD_BITS-1:0] dq_valid;
  logic [30:0]        dq_r [QD_BITS];
  logic [QD_BITS-1:0] dq_q [QD_BITS];
  logic [55:0]        dq_x [QD_BITS];
  logic [30:0]        dq_b [QD_BITS];
  logic               dq_neg [QD_BITS];
  tail_t              dq_tail [QD_BITS];

  logic               fin_valid;
  logic [127:0]       fin_data;
  tail_t              ft;
  logic signed [32:0] qv;
  logic signed [31:0] jso, f_du, f_dw;

  logic               skid_valid;
  logic [127:0]       skid_data;

  assign cfg_ready = 1'b1;
  assign adv       = !skid_valid;
  assign s_tready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_regs[i] <= CFG_RESET[i];
      end
    end else if (cfg_valid && cfg_index < CFG_INDEX_W'(NUM_CFG)) begin
      cfg_regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      sd_valid  <= '0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      dq_valid  <= '0;
      fin_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= s_tvalid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      sd_valid  <= {sd_valid[SD_LEN-2:0], s5_valid};
      s6_valid  <= sd_valid[SD_LEN-1];
      s7_valid  <= s6_valid;
      dq_valid  <= {dq_valid[QD_BITS-2:0], s7_valid};
      fin_valid <= dq_valid[QD_BITS-1];
    end
  end

  always_comb begin
    dv_a = s2_hv ? $signed(32'(s2_gv))
                 : sat32((s2_vinf ? 64'(ONE) : 64'sd0) - $signed(64'(s2_gv)));
    dv_b = s2_hv ? R_TAUVP : (s2_hvm ? R_TAUV2 : R_TAUV1);
    dv_p = qmul(dv_a, dv_b);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u  <= s_tdata[31:0];
      s1_gv <= s_tdata[56:32];
      s1_gw <= s_tdata[81:57];
      s1_gs <= s_tdata[106:82];

      s2_d_thv <= sat32(64'(s1_u) - 64'(cfg_regs[CFG_FAST_THRESHOLD]));
      s2_d_uu  <= sat32(64'(cfg_regs[CFG_UPPER_POTENTIAL]) - 64'(s1_u));
      s2_d_uso <= sat32(64'(s1_u) - 64'(cfg_regs[CFG_SO_MIDPOINT]));
      s2_d_uo  <= sat32(64'(s1_u) - 64'(cfg_regs[CFG_REST_OFFSET]));
      s2_d_uw  <= sat32(64'(s1_u) - 64'(C_UW));
      s2_d_us  <= sat32(64'(s1_u) - 64'(cfg_regs[CFG_S_MIDPOINT]));
      s2_u100  <= sat32(64'(s1_u) * C_WINF_GAIN);
      s2_hv    <= 64'(s1_u) > 64'(cfg_regs[CFG_FAST_THRESHOLD]);
      s2_hw    <= 64'(s1_u) > 64'(cfg_regs[CFG_SLOW_THRESHOLD]);
      s2_hvm   <= 64'(s1_u) > 64'(cfg_regs[CFG_V_TAU_THRESHOLD]);
      s2_ho    <= 64'(s1_u) > 64'(cfg_regs[CFG_O_THRESHOLD]);
      s2_vinf  <= 64'(s1_u) < 64'(cfg_regs[CFG_V_TAU_THRESHOLD]);
      s2_gv    <= s1_gv;
      s2_gw    <= s1_gw;
      s2_gs    <= s1_gs;

      s3_p1      <= qmul(s2_d_thv, s2_d_uu);
      s3_z1      <= qmul(C_KSO, s2_d_uso);
      s3_z2      <= sat32(64'(s2_d_uw) * C_KW);
      s3_z3      <= qmul(C_KS, s2_d_us);
      s3_gws     <= qmul($signed(32'(s2_gw)), $signed(32'(s2_gs)));
      s3_jso_lin <= qmul(s2_d_uo, s2_ho ? R_TAUO2 : R_TAUO1);
      s3_dv      <= s2_hv ? sat32(-64'(dv_p)) : dv_p;
      s3_dw_fix  <= sat32(-64'(qmul($signed(32'(s2_gw)), R_TAUWP)));
      s3_winf    <= s2_ho ? C_WINFSTAR : sat32(64'(ONE) - 64'(s2_u100));
      s3_hv      <= s2_hv;
      s3_hw      <= s2_hw;
      s3_gv      <= s2_gv;
      s3_gw      <= s2_gw;
      s3_gs      <= s2_gs;

      s4_p2      <= qmul(s3_p1, $signed(32'(s3_gv)));
      s4_q2      <= qmul(s3_gws, R_TAUSI);
      s4_wg      <= sat32(64'(s3_winf) - $signed(64'(s3_gw)));
      s4_jso_lin <= s3_jso_lin;
      s4_dv      <= s3_dv;
      s4_dw_fix  <= s3_dw_fix;
      s4_hv      <= s3_hv;
      s4_hw      <= s3_hw;
      s4_gs      <= s3_gs;

      s5_side.hv      <= s4_hv;
      s5_side.hw      <= s4_hw;
      s5_side.jfi_mag <= s4_hv ? qmul(s4_p2, R_TAUFI) : 32'sd0;
      s5_side.jsi_mag <= s4_hw ? s4_q2 : 32'sd0;
      s5_side.jso_lin <= s4_jso_lin;
      s5_side.dv      <= s4_dv;
      s5_side.dw_fix  <= s4_dw_fix;
      s5_side.wg      <= s4_wg;
      s5_side.gs      <= s4_gs;

      sd[0] <= s5_side;
      for (int i = 1; i < SD_LEN; i++) begin
        sd[i] <= sd[i-1];
      end

      s6_tauso <= sat32(64'(C_TAUSO1) + 64'(qmul(C_TAUSO_DIFF, $signed(32'(sig1)))));
      s6_tauwm <= sat32(64'(C_TAUW1) + 64'(qmul(C_TAUW_DIFF, $signed(32'(sig2)))));
      s6_wg    <= sd_last.wg;
      s6_tail.hw      <= sd_last.hw;
      s6_tail.jfi_mag <= sd_last.jfi_mag;
      s6_tail.jsi_mag <= sd_last.jsi_mag;
      s6_tail.jso_lin <= sd_last.jso_lin;
      s6_tail.dv      <= sd_last.dv;
      s6_tail.dw_fix  <= sd_last.dw_fix;
      s6_tail.ds      <= qmul(sat32($signed(64'(sig3)) - $signed(64'(sd_last.gs))),
                              sd_last.hw ? R_TAUS2 : R_TAUS1);

      s7_tail <= s6_tail;
      if (s6_tail.hw) begin
        s7_b   <= s6_tauso[30:0];
        s7_neg <= 1'b0;
        s7_x   <= {32'(ONE), 24'd0} + 56'(s6_tauso[30:1]);
      end else begin
        s7_b   <= s6_tauwm[30:0];
        s7_neg <= s6_wg[31];
        s7_x   <= {wg_mag, 24'd0} + 56'(s6_tauwm[30:1]);
      end

      fin_data <= {ft.ds, f_dw, ft.dv, f_du};
    end
  end

  assign sd_last = sd[SD_LEN-1];
  assign wg_mag  = s6_wg[31] ? 32'(-33'(s6_wg)) : 32'(s6_wg);

  mimr_sigmoid u_sig_so (.clk(clk), .en(adv), .x(s3_z1), .sig(sig1));
  mimr_sigmoid u_sig_w  (.clk(clk), .en(adv), .x(s3_z2), .sig(sig2));
  mimr_sigmoid u_sig_s  (.clk(clk), .en(adv), .x(s3_z3), .sig(sig3));

  for (genvar k = 0; k < QD_BITS; k++) begin : g_qdiv
    logic [30:0]        r_in, b_in, r_nx;
    logic [QD_BITS-1:0] q_in;
    logic [55:0]        x_in;
    logic               n_in, ge;
    tail_t              t_in;
    logic [31:0]        rr;
    if (k == 0) begin : g_first
      assign r_in = 31'(s7_x[55:QD_BITS]);
      assign q_in = '0;
      assign x_in = s7_x;
      assign b_in = s7_b;
      assign n_in = s7_neg;
      assign t_in = s7_tail;
    end else begin : g_rest
      assign r_in = dq_r[k-1];
      assign q_in = dq_q[k-1];
      assign x_in = dq_x[k-1];
      assign b_in = dq_b[k-1];
      assign n_in = dq_neg[k-1];
      assign t_in = dq_tail[k-1];
    end
    always_comb begin
      rr   = {r_in, x_in[QD_BITS-1-k]};
      ge   = rr >= {1'b0, b_in};
      r_nx = ge ? 31'(rr - {1'b0, b_in}) : rr[30:0];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dq_r[k]    <= r_nx;
        dq_q[k]    <= {q_in[QD_BITS-2:0], ge};
        dq_x[k]    <= x_in;
        dq_b[k]    <= b_in;
        dq_neg[k]  <= n_in;
        dq_tail[k] <= t_in;
      end
    end
  end

  always_comb begin
    ft   = dq_tail[QD_BITS-1];
    qv   = dq_neg[QD_BITS-1] ? -$signed(33'(dq_q[QD_BITS-1]))
                             : $signed(33'(dq_q[QD_BITS-1]));
    jso  = ft.hw ? $signed(32'(dq_q[QD_BITS-1])) : ft.jso_lin;
    f_du = sat32(64'(ft.jfi_mag) + 64'(ft.jsi_mag) - 64'(jso));
    f_dw = ft.hw ? ft.dw_fix : sat32(64'(qv));
  end

  // hold the output beat, park one more in the skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || fin_valid;
      skid_valid <= 1'b0;
    end else if (!skid_valid && fin_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_data : fin_data;
    end else if (!skid_valid) begin
      skid_data <= fin_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage full while output empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid stage filled without an output stall");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dq_valid[QD_BITS-1] |-> (dq_r[QD_BITS-1] < dq_b[QD_BITS-1]))
    else $error("quotient remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (fin_valid && !s_tready) |=> $stable(fin_data))
    else $error("final stage changed during stall");
`endif

endmodule
